>>> design/assert_macros.svh
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/tbsm_pkg.sv
// Shared widths and controller/datapath interface types for the batch splitter.
package tbsm_pkg;

	localparam int TAG_W  = 16;
	localparam int OFF_W  = 32;
	localparam int LEN_W  = 32;
	localparam int PLEN_W = 21;
	localparam int CNT_W  = 21;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // take the incoming request
		logic step;   // emit the next piece of a split request
	} tbsm_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic more;        // incoming request splits into more than one piece
		logic piece_last;  // piece now being formed is the final one
	} tbsm_sts_t;

endpackage

>>> design/transfer_batch_split_merge.sv
// Transfer batch splitter/merger. Each request (tag, offset, length) yields
// pieces grouped into push messages of at most MAX_PUSH_BYTES: a request that
// fits joins the open push; one that overflows closes it and opens a new
// push; a request of at least MAX_PUSH_BYTES is cut into limit-sized pieces
// by the single piece cutter in the datapath, one per cycle while the output
// is not stalled. Requests longer than MAX_PIECES * MAX_PUSH_BYTES give one
// result with too_long set. The single result register lets the next request
// enter in the cycle the waiting result is taken; while a result is stalled
// the input is stalled too.
`include "assert_macros.svh"

module transfer_batch_split_merge import tbsm_pkg::*; #(
	parameter int unsigned MAX_PUSH_BYTES = 1048576,
	parameter int unsigned MAX_PIECES     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TAG_W-1:0]  entry_tag,
	input  logic [OFF_W-1:0]  entry_offset,
	input  logic [LEN_W-1:0]  entry_len,
	input  logic              last_entry,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TAG_W-1:0]  piece_tag,
	output logic [OFF_W-1:0]  piece_offset,
	output logic [PLEN_W-1:0] piece_len,
	output logic              starts_push,
	output logic              too_long,
	output logic              list_done,
	output logic              run_last
);

	tbsm_cmd_t cmd;
	tbsm_sts_t sts;

	tbsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	tbsm_datapath #(
		.MAX_PUSH_BYTES (MAX_PUSH_BYTES),
		.MAX_PIECES     (MAX_PIECES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_tag    (entry_tag),
		.entry_offset (entry_offset),
		.entry_len    (entry_len),
		.last_entry   (last_entry),
		.piece_tag    (piece_tag),
		.piece_offset (piece_offset),
		.piece_len    (piece_len),
		.starts_push  (starts_push),
		.too_long     (too_long),
		.list_done    (list_done),
		.run_last     (run_last)
	);

	// Every accepted request leaves a result in the output register
	`ASSERT_NEXT(a_load_gives_result, clk, arst_n, in_valid && !in_stall, out_valid)
	// A rejected request gives a single empty result
	`ASSERT_IMPLIES(a_reject_empty, clk, arst_n, out_valid && too_long, piece_len == '0)
	`ASSERT_IMPLIES(a_reject_shape, clk, arst_n, out_valid && too_long, run_last && !starts_push)
	// A piece that does not open a push is a joined request, always alone
	`ASSERT_IMPLIES(a_join_single, clk, arst_n, out_valid && !starts_push && !too_long, run_last)
	// List end marks only the final result of a request
	`ASSERT_IMPLIES(a_done_on_last, clk, arst_n, out_valid && list_done, run_last)

endmodule

>>> design/tbsm_ctrl.sv
// Controller: accepts requests, walks split requests and owns the output valid.
module tbsm_ctrl import tbsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output tbsm_cmd_t cmd,
	input  tbsm_sts_t sts
);

	typedef enum logic {
		ST_IDLE,
		ST_SPLIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output register may be loaded when empty or being drained this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign cmd.load  = in_valid && !in_stall;
	assign cmd.step  = (state_q == ST_SPLIT) && out_free;
	assign out_valid = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && sts.more) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (cmd.step && sts.piece_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/tbsm_datapath.sv
// Datapath: push byte count, split cursor and the result register.
module tbsm_datapath import tbsm_pkg::*; #(
	parameter int unsigned MAX_PUSH_BYTES = 1048576,
	parameter int unsigned MAX_PIECES     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tbsm_cmd_t         cmd,
	output tbsm_sts_t         sts,
	input  logic [TAG_W-1:0]  entry_tag,
	input  logic [OFF_W-1:0]  entry_offset,
	input  logic [LEN_W-1:0]  entry_len,
	input  logic              last_entry,
	output logic [TAG_W-1:0]  piece_tag,
	output logic [OFF_W-1:0]  piece_offset,
	output logic [PLEN_W-1:0] piece_len,
	output logic              starts_push,
	output logic              too_long,
	output logic              list_done,
	output logic              run_last
);

	localparam logic [LEN_W-1:0] LIM = LEN_W'(MAX_PUSH_BYTES);
	localparam logic [LEN_W-1:0] CAP = LEN_W'(MAX_PIECES * MAX_PUSH_BYTES);

	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  rem_q;
	logic [OFF_W-1:0]  cur_off_q;
	logic [TAG_W-1:0]  tag_q;
	logic              last_q;

	logic [TAG_W-1:0]  piece_tag_q;
	logic [OFF_W-1:0]  piece_off_q;
	logic [PLEN_W-1:0] piece_len_q;
	logic              starts_q;
	logic              too_long_q;
	logic              list_done_q;
	logic              run_last_q;

	logic [LEN_W:0]    sum;
	logic              gt_cap;
	logic              close_push;
	logic              split;
	logic [CNT_W-1:0]  join_base;
	logic [CNT_W-1:0]  join_cnt;
	logic [LEN_W-1:0]  src_len;
	logic [OFF_W-1:0]  src_off;
	logic              piece_last;
	logic [PLEN_W-1:0] piece_w;

	// Classify the incoming request against the open push
	assign sum        = {1'b0, entry_len} + (LEN_W+1)'(cnt_q);
	assign gt_cap     = entry_len > CAP;
	assign close_push = (sum >= {1'b0, LIM}) && (cnt_q != '0) && !gt_cap;
	assign split      = !gt_cap && (entry_len >= LIM);
	assign join_base  = close_push ? '0 : cnt_q;
	assign join_cnt   = join_base + entry_len[CNT_W-1:0];

	// Piece cutter: first piece from the request, later ones from the cursor
	assign src_len    = cmd.load ? entry_len : rem_q;
	assign src_off    = cmd.load ? entry_offset : cur_off_q;
	assign piece_last = src_len <= LIM;
	assign piece_w    = piece_last ? src_len[PLEN_W-1:0] : LIM[PLEN_W-1:0];

	assign sts.more       = split && !piece_last;
	assign sts.piece_last = piece_last;

	// Open push byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			if (last_entry || split) begin
				cnt_q <= '0;
			end else if (!gt_cap) begin
				cnt_q <= join_cnt;
			end
		end
	end

	// Split cursor and request context
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.step) begin
			rem_q     <= src_len - LIM;
			cur_off_q <= src_off + LIM;
		end
		if (cmd.load) begin
			tag_q  <= entry_tag;
			last_q <= last_entry;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			piece_tag_q <= entry_tag;
			piece_off_q <= entry_offset;
			if (gt_cap) begin
				piece_len_q <= '0;
				starts_q    <= 1'b0;
				too_long_q  <= 1'b1;
				run_last_q  <= 1'b1;
				list_done_q <= last_entry;
			end else if (split) begin
				piece_len_q <= piece_w;
				starts_q    <= 1'b1;
				too_long_q  <= 1'b0;
				run_last_q  <= piece_last;
				list_done_q <= last_entry && piece_last;
			end else begin
				piece_len_q <= entry_len[PLEN_W-1:0];
				starts_q    <= (join_base == '0);
				too_long_q  <= 1'b0;
				run_last_q  <= 1'b1;
				list_done_q <= last_entry;
			end
		end else if (cmd.step) begin
			piece_tag_q <= tag_q;
			piece_off_q <= src_off;
			piece_len_q <= piece_w;
			starts_q    <= 1'b1;
			too_long_q  <= 1'b0;
			run_last_q  <= piece_last;
			list_done_q <= last_q && piece_last;
		end
	end

	assign piece_tag    = piece_tag_q;
	assign piece_offset = piece_off_q;
	assign piece_len    = piece_len_q;
	assign starts_push  = starts_q;
	assign too_long     = too_long_q;
	assign list_done    = list_done_q;
	assign run_last     = run_last_q;

endmodule

>>> sim/push_piece_checker.sv
// Checker for the transfer batch splitter: predicts push pieces per request and compares.
`timescale 1ns / 1ps

module push_piece_checker import tbsm_pkg::*; #(
	parameter int unsigned MAX_PUSH_BYTES = 1048576,
	parameter int unsigned MAX_PIECES     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [TAG_W-1:0]  entry_tag,
	input  logic [OFF_W-1:0]  entry_offset,
	input  logic [LEN_W-1:0]  entry_len,
	input  logic              last_entry,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [TAG_W-1:0]  piece_tag,
	input  logic [OFF_W-1:0]  piece_offset,
	input  logic [PLEN_W-1:0] piece_len,
	input  logic              starts_push,
	input  logic              too_long,
	input  logic              list_done,
	input  logic              run_last,
	output int                mismatches,
	output int                awaited
);

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [OFF_W-1:0]  offset;
		logic [PLEN_W-1:0] len;
		logic              starts;
		logic              rejected;
		logic              done;
		logic              last;
	} piece_t;

	piece_t           piece_q[$];
	logic [CNT_W-1:0] push_fill = '0;  // bytes held by the open push

	// Work out the pieces one request produces and queue them in order
	function automatic void predict_pieces(input logic [TAG_W-1:0] tag,
			input logic [OFF_W-1:0] offset, input logic [LEN_W-1:0] len,
			input logic last);
		longint unsigned lim, cap, fill, total, sent, rest, chunk;
		int              count;
		piece_t          p;
		lim   = MAX_PUSH_BYTES;
		cap   = longint'(MAX_PIECES) * lim;
		fill  = push_fill;
		total = len;
		count = 0;
		// an overflowing request closes the open push first
		if (total + fill >= lim && fill != 0 && total <= cap)
			fill = 0;
		if (total > cap) begin
			p          = '0;
			p.tag      = tag;
			p.offset   = offset;
			p.rejected = 1'b1;
			piece_q.insert(piece_q.size(), p);
		end else if (total + fill >= lim) begin
			// cut into limit-sized pieces, each its own push
			sent = 0;
			while (sent < total && count < MAX_PIECES) begin
				rest     = total - sent;
				chunk    = (rest < lim) ? rest : lim;
				p        = '0;
				p.tag    = tag;
				p.offset = offset + sent[OFF_W-1:0];
				p.len    = chunk[PLEN_W-1:0];
				p.starts = 1'b1;
				piece_q.insert(piece_q.size(), p);
				sent += chunk;
				count++;
			end
			fill = 0;
		end else begin
			// joins the open push, or opens one when empty
			p        = '0;
			p.tag    = tag;
			p.offset = offset;
			p.len    = len[PLEN_W-1:0];
			p.starts = (fill == 0);
			piece_q.insert(piece_q.size(), p);
			fill = fill + total;
		end
		piece_q[piece_q.size()-1].last = 1'b1;
		if (last) begin
			piece_q[piece_q.size()-1].done = 1'b1;
			fill = 0;
		end
		push_fill = fill[CNT_W-1:0];
	endfunction

	// Predict on each accepted request, compare each accepted piece
	always @(posedge clk) begin
		piece_t got, want;
		if (!arst_n) begin
			push_fill  = '0;
			mismatches = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_pieces(entry_tag, entry_offset, entry_len, last_entry);
			if (out_valid && !out_stall) begin
				got = {piece_tag, piece_offset, piece_len, starts_push, too_long,
					list_done, run_last};
				if (piece_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected piece tag %h off %h len %h sp %b tl %b ld %b rl %b",
							$realtime, got.tag, got.offset, got.len, got.starts,
							got.rejected, got.done, got.last);
				end else begin
					want = piece_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: piece mismatch", $realtime);
							$display("  expected tag %h off %h len %h sp %b tl %b ld %b rl %b",
								want.tag, want.offset, want.len, want.starts,
								want.rejected, want.done, want.last);
							$display("  actual   tag %h off %h len %h sp %b tl %b ld %b rl %b",
								got.tag, got.offset, got.len, got.starts,
								got.rejected, got.done, got.last);
						end
					end
				end
			end
		end
		awaited <= piece_q.size();
	end

endmodule

>>> sim/transfer_batch_split_merge_tb.sv
// Testbench top for the transfer batch splitter: clock, reset, requests and the verdict.
`timescale 1ns / 1ps

module transfer_batch_split_merge_tb;
	import tbsm_pkg::*;

	localparam int unsigned PUSH_LIMIT  = 1048576;
	localparam int unsigned PIECE_LIMIT = 64;
	localparam int unsigned SPLIT_CAP   = PUSH_LIMIT * PIECE_LIMIT;
	localparam int          RAND_ITEMS  = 240;
	localparam int          HANG_CYCLES = 2000;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [TAG_W-1:0]  entry_tag    = '0;
	logic [OFF_W-1:0]  entry_offset = '0;
	logic [LEN_W-1:0]  entry_len    = '0;
	logic              last_entry   = 1'b0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [TAG_W-1:0]  piece_tag;
	logic [OFF_W-1:0]  piece_offset;
	logic [PLEN_W-1:0] piece_len;
	logic              starts_push;
	logic              too_long;
	logic              list_done;
	logic              run_last;

	int   mismatches;
	int   awaited;
	int   hang_count = 0;
	logic quiet      = 1'b0;  // suppresses idling on both sides

	transfer_batch_split_merge #(
		.MAX_PUSH_BYTES(PUSH_LIMIT),
		.MAX_PIECES    (PIECE_LIMIT)
	) u_top (.*);

	push_piece_checker #(
		.MAX_PUSH_BYTES(PUSH_LIMIT),
		.MAX_PIECES    (PIECE_LIMIT)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 9);
	end

	// Watchdog: nothing accepted for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				hang_count <= 0;
			else
				hang_count <= hang_count + 1;
			if (hang_count >= HANG_CYCLES) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Present one request and hold it until accepted
	task automatic send_request(input logic [TAG_W-1:0] tag, input logic [OFF_W-1:0] offset,
			input logic [LEN_W-1:0] len, input logic last);
		if (!quiet) begin
			while ($urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		entry_tag    <= tag;
		entry_offset <= offset;
		entry_len    <= len;
		last_entry   <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold off new requests until every queued piece has come out
	task automatic drain_pushes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	// Mostly small lengths that merge, some splits, a few at the cap and beyond
	function automatic logic [LEN_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)      return $urandom_range(0, 4095);
		else if (r < 52) return $urandom_range(0, PUSH_LIMIT / 4);
		else if (r < 66) return $urandom_range(PUSH_LIMIT / 2, PUSH_LIMIT - 1);
		else if (r < 70) return '0;
		else if (r < 77) return $urandom_range(PUSH_LIMIT - 1, PUSH_LIMIT + 1);
		else if (r < 86) return $urandom_range(PUSH_LIMIT + 1, 6 * PUSH_LIMIT);
		else if (r < 88) return $urandom_range(SPLIT_CAP - PUSH_LIMIT, SPLIT_CAP);
		else if (r < 90) return $urandom_range(SPLIT_CAP, SPLIT_CAP + 1);
		else             return $urandom_range(SPLIT_CAP + 1, 32'hFFFF_FFFF);
	endfunction

	initial begin
		int items;
		int run_len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundaries of the push limit, splits, rejects, list ends
		send_request(16'h0000, 32'h0000_0000, 32'd0, 1'b0);              // empty request
		send_request(16'hFFFF, 32'h0000_1000, 32'd100, 1'b0);
		send_request(16'h1234, 32'h0001_0000, PUSH_LIMIT - 101, 1'b0);    // fill to limit-1
		send_request(16'h1235, 32'h0002_0000, 32'd1, 1'b0);               // hits limit exactly
		send_request(16'h1236, 32'h0003_0000, PUSH_LIMIT - 1, 1'b0);
		send_request(16'h1237, 32'h0004_0000, 32'd0, 1'b0);               // zero joins open push
		send_request(16'h5555, 32'h0005_0000, PUSH_LIMIT, 1'b0);          // one full piece
		send_request(16'hAAAA, 32'h0006_0000, PUSH_LIMIT + 1, 1'b0);      // two pieces
		send_request(16'h0001, 32'hFFFF_F000, SPLIT_CAP, 1'b0);           // max pieces, wraps
		send_request(16'h0002, 32'h0007_0000, 32'd500, 1'b0);
		send_request(16'h0003, 32'h0008_0000, SPLIT_CAP + 1, 1'b0);       // reject, push kept
		send_request(16'h0004, 32'h0009_0000, 32'd600, 1'b0);
		send_request(16'h0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);       // reject ends list
		send_request(16'h0006, 32'h000A_0000, 32'd300, 1'b1);             // one-entry list
		send_request(16'h0007, 32'h000B_0000, 32'd700, 1'b0);
		send_request(16'h0008, 32'hFFFF_FFF0, 3 * PUSH_LIMIT + 5, 1'b1);  // split ends list
		send_request(16'h0009, 32'h000C_0000, 32'h5555_5555, 1'b0);
		send_request(16'h000A, 32'h000D_0000, 32'hAAAA_AAAA, 1'b0);
		send_request(16'h000B, 32'hFFFF_FFFF, 32'd16, 1'b0);
		send_request(16'h000C, 32'h000E_0000, 32'd0, 1'b1);               // empty list end
		drain_pushes();

		// random lists of requests
		items = 0;
		while (items < RAND_ITEMS) begin
			run_len = $urandom_range(1, 12);
			for (int k = 0; k < run_len; k++) begin
				quiet = (items >= 90 && items < 150);
				send_request(TAG_W'($urandom_range(0, 65535)), $urandom(), pick_len(),
					k == run_len - 1);
				items++;
				if (items == 200)
					drain_pushes();
			end
		end

		drain_pushes();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> transfer_batch_split_merge.f
+incdir+design
design/tbsm_pkg.sv
design/tbsm_ctrl.sv
design/tbsm_datapath.sv
design/transfer_batch_split_merge.sv
sim/push_piece_checker.sv
sim/transfer_batch_split_merge_tb.sv
